@@ rtl/core/bsa_pkg.sv @@
`timescale 1ns / 1ps

package bsa_pkg;

   // The slot map is held as 32-bit words; one word is examined per cycle while no response stall holds the scan.
   localparam int WORD_W   = 32;
   localparam int OFFSET_W = 5;

   typedef enum logic [2:0] {
      ACT_SET       = 3'd0,
      ACT_CLEAR     = 3'd1,
      ACT_ALLOC     = 3'd2,
      ACT_TEST      = 3'd3,
      ACT_FIND      = 3'd4,
      ACT_CLEAR_ALL = 3'd5
   } action_type;

   typedef struct packed {
      logic                hit;
      logic [OFFSET_W-1:0] bit_idx;
   } scan_result_type;

endpackage

@@ rtl/core/bsa_map_mem.sv @@
`timescale 1ns / 1ps

module bsa_map_mem
   import bsa_pkg::*;
#(
   parameter int WORDS  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bsa_scan_unit.sv @@
`timescale 1ns / 1ps

module bsa_scan_unit
   import bsa_pkg::*;
(
   input  logic [WORD_W-1:0]   word_data,
   input  logic                want_set,
   input  logic [OFFSET_W-1:0] start_bit,
   input  logic [WORD_W-1:0]   limit_mask,
   output scan_result_type     result
);

   logic [WORD_W-1:0] cand;

   // Lowest candidate bit at or above start_bit wins.
   always_comb begin
      cand   = (want_set ? word_data : ~word_data)
               & ({WORD_W{1'b1}} << start_bit) & limit_mask;
      result = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            result.hit     = 1'b1;
            result.bit_idx = OFFSET_W'(i);
         end
      end
   end

endmodule

@@ rtl/core/bitmap_slot_allocator.sv @@
`timescale 1ns / 1ps

// Bitmap slot allocator. The map of SLOTS one-bit slots lives in a word-wide memory
// of ceil(SLOTS/32) 32-bit words with a single read and a single write port, and a
// small sequencer drives one shared find-first unit across it. Requests are taken
// only while the sequencer is idle. Set, clear and test read the word in the accept
// cycle and evaluate it in the scan state. Alloc and find-next scan word by word,
// starting at the word holding pos and stopping at the first hit or at the last
// word of the map. Clear-all rewrites the memory one word per cycle, and after
// reset the same sweep clears the map before the first request is accepted. A
// finished response sits in an output register. While it has not been taken,
// searches and single-slot actions wait, and a clear-all sweep waits at its last
// word. The response index carries the low eight bits of the slot number.

module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [7:0] req_pos,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_index,
   output logic       rsp_found,
   output logic       rsp_bit_value
);

   localparam int WORDS     = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LAST_BITS = SLOTS - (WORDS - 1) * WORD_W;
   localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_CLEAR  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   action_type          act_ff, act_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [WADDR_W-1:0]  cur_word_ff, cur_word_in;
   logic                first_ff, first_in;
   logic                clr_reply_ff, clr_reply_in;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_index_ff;
   logic                rsp_found_ff;
   logic                rsp_bit_ff;

   logic                emit;
   logic [7:0]          emit_index;
   logic                emit_found;
   logic                emit_bit;

   logic                wr_en;
   logic [WADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [WADDR_W-1:0]  rd_addr;
   logic [WORD_W-1:0]   word_data;

   logic                stall;
   logic                last_word;
   logic                pos_inside;
   logic [WADDR_W-1:0]  start_word;
   logic                want_set;
   logic [OFFSET_W-1:0] scan_start;
   logic [WORD_W-1:0]   limit_mask;
   scan_result_type     scan;
   logic [7:0]          hit_index;

   bsa_map_mem #(
      .WORDS  (WORDS),
      .ADDR_W (WADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (word_data)
   );

   // Only the first word of a search starts mid-word; the last word hides the
   // bits that lie beyond the end of the map.
   assign want_set   = (act_ff == ACT_FIND);
   assign scan_start = first_ff ? offset_ff : '0;
   assign limit_mask = last_word ? LAST_MASK : {WORD_W{1'b1}};

   bsa_scan_unit u_scan (
      .word_data  (word_data),
      .want_set   (want_set),
      .start_bit  (scan_start),
      .limit_mask (limit_mask),
      .result     (scan)
   );

   assign stall      = rsp_valid_ff & ~rsp_ready;
   assign last_word  = (cur_word_ff == LAST_WORD);
   assign pos_inside = (32'(req_pos) < 32'(SLOTS));
   assign start_word = WADDR_W'(req_pos >> OFFSET_W);
   assign hit_index  = 8'({cur_word_ff, scan.bit_idx});
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      offset_in    = offset_ff;
      cur_word_in  = cur_word_ff;
      first_in     = first_ff;
      clr_reply_in = clr_reply_ff;
      emit         = 1'b0;
      emit_index   = '0;
      emit_found   = 1'b0;
      emit_bit     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_word_ff;
      wr_data      = word_data;
      rd_addr      = cur_word_ff;

      case (state_ff)
         ST_IDLE: begin
            // The word holding pos is read in the accept cycle itself.
            rd_addr = pos_inside ? start_word : '0;
            if (req_valid) begin
               act_in      = action_type'(req_action);
               offset_in   = req_pos[OFFSET_W-1:0];
               cur_word_in = pos_inside ? start_word : '0;
               first_in    = 1'b1;
               case (action_type'(req_action))
                  ACT_SET, ACT_CLEAR, ACT_ALLOC, ACT_TEST, ACT_FIND: begin
                     state_in = pos_inside ? ST_SCAN : ST_FINISH;
                  end
                  ACT_CLEAR_ALL: begin
                     state_in     = ST_CLEAR;
                     cur_word_in  = '0;
                     clr_reply_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Prefetch the following word so a miss moves on one word per cycle when not stalled.
            // While stalled the current word is read again and stays in place.
            rd_addr = (stall || last_word) ? cur_word_ff : cur_word_ff + 1'b1;
            if (!stall) begin
               case (act_ff)
                  ACT_SET: begin
                     wr_en              = 1'b1;
                     wr_data[offset_ff] = 1'b1;
                     emit               = 1'b1;
                     state_in           = ST_IDLE;
                  end
                  ACT_CLEAR: begin
                     wr_en              = 1'b1;
                     wr_data[offset_ff] = 1'b0;
                     emit               = 1'b1;
                     state_in           = ST_IDLE;
                  end
                  ACT_TEST: begin
                     emit_bit = word_data[offset_ff];
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
                  ACT_ALLOC, ACT_FIND: begin
                     if (scan.hit) begin
                        if (act_ff == ACT_ALLOC) begin
                           wr_en                 = 1'b1;
                           wr_data[scan.bit_idx] = 1'b1;
                        end
                        emit_index = hit_index;
                        emit_found = 1'b1;
                        emit       = 1'b1;
                        state_in   = ST_IDLE;
                     end else if (last_word) begin
                        emit     = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        cur_word_in = cur_word_ff + 1'b1;
                        first_in    = 1'b0;
                     end
                  end
                  default: begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_FINISH: begin
            if (!stall) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_CLEAR: begin
            // One word cleared per cycle; rewriting the last word while the
            // response waits is harmless.
            wr_en   = 1'b1;
            wr_data = '0;
            if (last_word) begin
               if (!clr_reply_ff) begin
                  state_in = ST_IDLE;
               end else if (!stall) begin
                  emit         = 1'b1;
                  clr_reply_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               cur_word_in = cur_word_ff + 1'b1;
            end
         end

         default: begin
            state_in     = ST_CLEAR;
            cur_word_in  = '0;
            clr_reply_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_word_ff  <= '0;
         clr_reply_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_word_ff  <= cur_word_in;
         clr_reply_ff <= clr_reply_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      offset_ff <= offset_in;
   end

   // The response register frees the sequencer from the consumer's pace.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= emit_index;
         rsp_found_ff <= emit_found;
         rsp_bit_ff   <= emit_bit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_bit_value = rsp_bit_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb
   import bsa_pkg::*;
();

   localparam int MAP_SLOTS    = 256;
   localparam int PHASE_ITEMS  = 530;
   localparam int TAIL_CYCLES  = 24;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_LIMIT = 10;

   // The two action codes the block leaves unused. They must change nothing and
   // return an all-zero response.
   localparam logic [2:0] ACT_RSVD_LO = 3'd6;
   localparam logic [2:0] ACT_RSVD_HI = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_action;
   logic [7:0] req_pos;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_index;
   logic       rsp_found;
   logic       rsp_bit_value;

   // Percentage of cycles in which each side holds back. Changed per phase.
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;

   // The scoreboard keeps its own copy of the slot map. Every accepted request is
   // applied to that copy in order, and the response the block owes for it is
   // queued. Responses come back in request order, so the oldest queued entry is
   // always the one to compare against.
   class slot_map_scoreboard;
      typedef struct {
         logic [7:0] index;
         logic       found;
         logic       bit_value;
      } slot_reply_type;

      bit [MAP_SLOTS-1:0] slot_bits;
      slot_reply_type     replies_due[$];
      int                 failures;
      int                 action_seen[8];
      int                 alloc_misses;
      int                 find_misses;
      int                 responses_checked;

      function int first_slot_from(bit want, int start);
         for (int i = start; i < MAP_SLOTS; i++)
            if (slot_bits[i] == want) return i;
         return -1;
      endfunction

      function void note_request(logic [2:0] act, logic [7:0] p);
         slot_reply_type r;
         int             hit;
         r = '{index: 8'd0, found: 1'b0, bit_value: 1'b0};
         action_seen[act]++;
         case (act)
            ACT_SET: slot_bits[p] = 1'b1;
            ACT_CLEAR: slot_bits[p] = 1'b0;
            ACT_ALLOC: begin
               hit = first_slot_from(1'b0, p);
               if (hit >= 0) begin
                  slot_bits[hit] = 1'b1;
                  r.index = hit[7:0];
                  r.found = 1'b1;
               end else begin
                  alloc_misses++;
               end
            end
            ACT_TEST: r.bit_value = slot_bits[p];
            ACT_FIND: begin
               hit = first_slot_from(1'b1, p);
               if (hit >= 0) begin
                  r.index = hit[7:0];
                  r.found = 1'b1;
               end else begin
                  find_misses++;
               end
            end
            ACT_CLEAR_ALL: slot_bits = '0;
            default: ;
         endcase
         replies_due.push_back(r);
      endfunction

      function void check_response(logic [7:0] idx, logic fnd, logic bv);
         slot_reply_type want;
         if (replies_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] response with nothing outstanding: index=%0d found=%b bit=%b",
                        $realtime, idx, fnd, bv);
            return;
         end
         want = replies_due.pop_front();
         responses_checked++;
         if (idx !== want.index || fnd !== want.found || bv !== want.bit_value) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] expected index=%0d found=%b bit=%b, got index=%0d found=%b bit=%b",
                        $realtime, want.index, want.found, want.bit_value, idx, fnd, bv);
         end
      endfunction

      function int expected_count();
         return replies_due.size();
      endfunction
   endclass

   slot_map_scoreboard sb;

   bitmap_slot_allocator #(
      .SLOTS(MAP_SLOTS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_pos       (req_pos),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_index     (rsp_index),
      .rsp_found     (rsp_found),
      .rsp_bit_value (rsp_bit_value)
   );

   // 12 ns clock, low half first so no rising edge falls at time zero.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Response side. The handshake is judged on the values present just before the
   // edge, and the ready for the next cycle is rolled against the current stall rate.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_index, rsp_found, rsp_bit_value);
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog. A hung handshake or a lost response ends up here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d responses outstanding",
               cycle_count, sb.expected_count());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Presents one request and holds it until the block takes it. A random idle
   // stretch may come first; valid only drops when such a stretch is taken, so a
   // back-to-back request keeps valid high across the boundary.
   task automatic send_request(input logic [2:0] act, input logic [7:0] p);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_pos    <= p;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(act, p);
   endtask

   // Stops sending and waits until the block has answered everything taken so far.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.expected_count() != 0)
         @(posedge clock);
   endtask

   // Mostly allocs, since they are what fills the map and drives the searches
   // into the later words. Clear-all stays rare so the map gets a chance to fill.
   function automatic logic [2:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return ACT_CLEAR_ALL;
      if (r < 5) return ($urandom_range(0, 1) != 0) ? ACT_RSVD_HI : ACT_RSVD_LO;
      if (r < 40) return ACT_ALLOC;
      if (r < 55) return ACT_SET;
      if (r < 70) return ACT_CLEAR;
      if (r < 82) return ACT_TEST;
      return ACT_FIND;
   endfunction

   // Positions lean toward word boundaries and the top of the map, where the
   // scan has the least room and the not-found paths show up.
   function automatic logic [7:0] pick_pos();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) begin
         case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd31;
            2: return 8'd32;
            3: return 8'd224;
            4: return 8'd254;
            default: return 8'd255;
         endcase
      end
      if (r == 1) return 8'($urandom_range(192, 255));
      return 8'($urandom_range(0, 255));
   endfunction

   // Hand-picked opening: empty-map searches, the ends of the map, a search that
   // crosses a word boundary, the unused actions, and an alloc that finds no free
   // slot up to the end of the map.
   task automatic run_directed();
      send_request(ACT_TEST, 8'd0);
      send_request(ACT_FIND, 8'd0);
      send_request(ACT_ALLOC, 8'd0);
      send_request(ACT_SET, 8'd255);
      send_request(ACT_TEST, 8'd255);
      send_request(ACT_FIND, 8'd1);
      send_request(ACT_ALLOC, 8'd0);
      send_request(ACT_CLEAR, 8'd0);
      send_request(ACT_ALLOC, 8'd0);
      send_request(ACT_SET, 8'd31);
      send_request(ACT_FIND, 8'd2);
      send_request(ACT_SET, 8'd32);
      send_request(ACT_CLEAR, 8'd31);
      send_request(ACT_FIND, 8'd2);
      send_request(ACT_RSVD_LO, 8'd255);
      send_request(ACT_RSVD_HI, 8'd0);
      // Slots 250 to 254 fill one by one; 255 is already taken, so the sixth
      // alloc from 250 finds nothing.
      repeat (6) send_request(ACT_ALLOC, 8'd250);
      send_request(ACT_FIND, 8'd250);
      send_request(ACT_CLEAR_ALL, 8'd0);
      send_request(ACT_FIND, 8'd0);
      send_request(ACT_TEST, 8'd255);
   endtask

   // Random traffic. Now and then a burst of allocs from one start point packs
   // the map, at times until the search comes up empty.
   task automatic run_random_phase(input int count);
      int         sent;
      int         burst;
      logic [7:0] p;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 4) begin
            burst = $urandom_range(8, 40);
            p = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 63))
                                            : 8'($urandom_range(0, 255));
            repeat (burst) begin
               send_request(ACT_ALLOC, p);
               sent++;
            end
         end else begin
            send_request(pick_action(), pick_pos());
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= ACT_SET;
      req_pos    <= 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain_responses();

      // Slow receiver first, then a slow sender, then full rate. Each phase ends
      // with the sender waiting for every outstanding response.
      send_idle_pct = 36;
      recv_idle_pct = 85;
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      send_idle_pct = 85;
      recv_idle_pct = 36;
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(PHASE_ITEMS);
      drain_responses();

      // Give the block time to show any response it should not produce.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_count() != 0) begin
         sb.failures++;
         $display("%0d responses never arrived", sb.expected_count());
      end

      $display("Checked %0d responses: %0d set, %0d clear, %0d alloc, %0d test,",
               sb.responses_checked, sb.action_seen[ACT_SET], sb.action_seen[ACT_CLEAR],
               sb.action_seen[ACT_ALLOC], sb.action_seen[ACT_TEST]);
      $display("%0d find, %0d clear-all, %0d unused.",
               sb.action_seen[ACT_FIND], sb.action_seen[ACT_CLEAR_ALL],
               sb.action_seen[ACT_RSVD_LO] + sb.action_seen[ACT_RSVD_HI]);
      $display("Allocs with no free slot: %0d, finds with no marked slot: %0d, failures: %0d.",
               sb.alloc_misses, sb.find_misses, sb.failures);
      if (sb.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/bsa_pkg.sv
rtl/core/bsa_map_mem.sv
rtl/core/bsa_scan_unit.sv
rtl/core/bitmap_slot_allocator.sv
bench/tb.sv
